### hdl/pmst_pkg.sv
// ----------------------------------------------------------------------------
// pmst_pkg
// Types and codes used by the spanning tree engine.
// ----------------------------------------------------------------------------
`default_nettype none

package pmst_pkg;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_RUN   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [5:0]  first_vertex;
		logic [5:0]  second_vertex;
		logic [15:0] weight;
	} req_t;

	typedef struct packed {
		logic [5:0]  vertex;
		logic [5:0]  parent_vertex;
		logic [15:0] edge_weight;
		logic [21:0] total_weight;
		logic        unique_res;
		logic        connected;
		logic        last;
	} res_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_E_RD,
		ST_E_CMP,
		ST_E_WAB,
		ST_E_WBA,
		ST_P_INIT,
		ST_U_RD,
		ST_U_LAT,
		ST_SWEEP,
		ST_DRAIN,
		ST_SEL,
		ST_OUT,
		ST_OUT_DR
	} state_t;

	localparam int unsigned CFG_BITS = 7;

endpackage

`default_nettype wire

### hdl/pmst_relax.sv
// ----------------------------------------------------------------------------
// pmst_relax
// Edge cost and key relaxation for one neighbor of the vertex just added.
// ----------------------------------------------------------------------------
`default_nettype none

module pmst_relax #(
	parameter int unsigned WB = 16,
	parameter int unsigned VW = 6
) (
	input  wire logic [WB+1:0] wword,
	input  wire logic [WB:0]   old_key,
	input  wire logic          key_vld,
	input  wire logic          in_tree,
	input  wire logic [VW-1:0] x,
	input  wire logic [VW-1:0] x_par,
	input  wire logic          x_ok,
	input  wire logic [VW-1:0] u,
	input  wire logic [VW-1:0] u_par,
	input  wire logic          u_ok,
	input  wire logic          bump,
	output logic               upd,
	output logic [WB:0]        cost,
	output logic               cand,
	output logic [WB:0]        eff
);

	logic present;
	logic bump_it;

	always_comb begin
		present = !wword[WB];
		bump_it = bump && !wword[WB+1] &&
			((x_ok && (x_par == u)) || (u_ok && (u_par == x)));
		cost = {1'b0, wword[WB-1:0]} + {{WB{1'b0}}, bump_it};
		upd  = !in_tree && present && (!key_vld || (cost < old_key));
		eff  = upd ? cost : old_key;
		cand = !in_tree && (upd || key_vld);
	end

endmodule

`default_nettype wire

### hdl/prim_mst_with_uniqueness_check.sv
// ----------------------------------------------------------------------------
// prim_mst_with_uniqueness_check
// Weighted graph store with Prim spanning tree and uniqueness check.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// request   in         start & !busy             req   (pmst_pkg::req_t)
// result    out        res_valid, one cycle      res   (pmst_pkg::res_t)
// config    in         cfg_we                    cfg_wdata (vertex count)
//
// Add edge: busy through read, compare, and the writes of both symmetric entries.
// Clear: busy while every weight memory entry is written to "no edge".
// Run: two passes, each up to n steps that sweep one row through the weight memory
// read port, then n-1 results are output.
// After reset the weight memory is swept to "no edge" with busy high.
// Results cannot be stalled; busy gates requests.
// ----------------------------------------------------------------------------
`default_nettype none

module prim_mst_with_uniqueness_check #(
	parameter int unsigned MAX_VERTICES = 64,
	parameter int unsigned WEIGHT_BITS  = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire pmst_pkg::req_t                 req,
	output logic                                busy,
	output logic                                res_valid,
	output pmst_pkg::res_t                      res,
	input  wire logic                           cfg_we,
	input  wire logic [pmst_pkg::CFG_BITS-1:0]  cfg_wdata
);

	localparam int unsigned VW    = $clog2(MAX_VERTICES);
	localparam int unsigned CW    = $clog2(MAX_VERTICES + 1);
	localparam int unsigned DEPTH = MAX_VERTICES * MAX_VERTICES;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned WB    = WEIGHT_BITS;
	localparam int unsigned TW    = WEIGHT_BITS + 2 + VW;

	// weight word: tie, no-edge, weight
	logic [WB+1:0]    wmem [DEPTH];
	logic [VW+WB:0]   kmem [MAX_VERTICES];
	logic [VW+WB-1:0] tmem [MAX_VERTICES];

	pmst_pkg::state_t state_q, state_d;

	logic [pmst_pkg::CFG_BITS-1:0] vcount_q;
	logic [CW-1:0]  nv_q;
	logic [AW-1:0]  ca_q;
	logic [AW-1:0]  ab_q, ba_q;
	logic [WB-1:0]  ew_q;
	logic [WB+1:0]  nw_q;
	logic           doit_q;
	logic           pass_q;
	logic [VW-1:0]  u_q, upar_q, i_q, i_s1, minv_q, minpar_q;
	logic           uok_q, v_s1, fnd_q;
	logic [WB:0]    min_q;
	logic [AW-1:0]  row_q;
	logic [TW-1:0]  total_q, tot1_q;
	logic [CW-1:0]  cnt_q;
	logic           conn_q, uniq_q;
	logic [MAX_VERTICES-1:0] in_tree_q, key_vld_q, tree_ok_q;

	// memory ports
	logic          w_we;
	logic [AW-1:0] w_waddr, w_raddr;
	logic [WB+1:0] w_wdata, w_rd_q;
	logic [VW+WB:0] k_rd_q;
	logic          t_we;
	logic [VW-1:0] t_addr;
	logic [VW+WB-1:0] t_rd_q;

	logic [VW-1:0] a_v, b_v;
	logic          e_ok;
	logic [CW-1:0] nv_new;
	logic          i_last;
	logic          upd, cand;
	logic [WB:0]   cost, eff;
	logic          fin;

	always_ff @(posedge clk) begin
		if (w_we) begin
			wmem[w_waddr] <= w_wdata;
		end
		w_rd_q <= wmem[w_raddr];
	end

	always_ff @(posedge clk) begin
		if (v_s1 && upd) begin
			kmem[i_s1] <= {u_q, cost};
		end
		k_rd_q <= kmem[i_q];
	end

	always_ff @(posedge clk) begin
		if (t_we) begin
			tmem[t_addr] <= {minpar_q, min_q[WB-1:0]};
		end
		t_rd_q <= tmem[t_addr];
	end

	pmst_relax #(.WB(WB), .VW(VW)) u_relax (
		.wword   (w_rd_q),
		.old_key (k_rd_q[WB:0]),
		.key_vld (key_vld_q[i_s1]),
		.in_tree (in_tree_q[i_s1]),
		.x       (i_s1),
		.x_par   (t_rd_q[VW+WB-1:WB]),
		.x_ok    (tree_ok_q[i_s1]),
		.u       (u_q),
		.u_par   (upar_q),
		.u_ok    (uok_q),
		.bump    (pass_q),
		.upd     (upd),
		.cost    (cost),
		.cand    (cand),
		.eff     (eff)
	);

	always_comb begin
		a_v    = VW'(req.first_vertex);
		b_v    = VW'(req.second_vertex);
		e_ok   = (req.first_vertex != req.second_vertex) &&
			(32'(req.first_vertex) < MAX_VERTICES) &&
			(32'(req.second_vertex) < MAX_VERTICES);
		if (vcount_q == '0) begin
			nv_new = CW'(1);
		end else if (32'(vcount_q) > MAX_VERTICES) begin
			nv_new = CW'(MAX_VERTICES);
		end else begin
			nv_new = CW'(vcount_q);
		end
		i_last = (CW'(i_q) == (nv_q - CW'(1)));
		busy   = (state_q != pmst_pkg::ST_IDLE);
	end

	always_comb begin
		state_d = state_q;
		w_we    = 1'b0;
		w_waddr = ca_q;
		w_wdata = {1'b0, 1'b1, {WB{1'b0}}};
		w_raddr = row_q + AW'(i_q);
		t_we    = 1'b0;
		t_addr  = i_q;
		unique case (state_q)
			pmst_pkg::ST_CLEAR: begin
				w_we = 1'b1;
				if (ca_q == AW'(DEPTH - 1)) begin
					state_d = pmst_pkg::ST_IDLE;
				end
			end
			pmst_pkg::ST_IDLE: begin
				if (start) begin
					unique case (req.operation)
						pmst_pkg::OP_ADD:   state_d = e_ok ? pmst_pkg::ST_E_RD
						                                   : pmst_pkg::ST_IDLE;
						pmst_pkg::OP_RUN:   state_d = pmst_pkg::ST_P_INIT;
						pmst_pkg::OP_CLEAR: state_d = pmst_pkg::ST_CLEAR;
						default:            state_d = pmst_pkg::ST_IDLE;
					endcase
				end
			end
			pmst_pkg::ST_E_RD: begin
				w_raddr = ab_q;
				state_d = pmst_pkg::ST_E_CMP;
			end
			pmst_pkg::ST_E_CMP: begin
				state_d = pmst_pkg::ST_E_WAB;
			end
			pmst_pkg::ST_E_WAB: begin
				w_we    = doit_q;
				w_waddr = ab_q;
				w_wdata = nw_q;
				state_d = pmst_pkg::ST_E_WBA;
			end
			pmst_pkg::ST_E_WBA: begin
				w_we    = doit_q;
				w_waddr = ba_q;
				w_wdata = nw_q;
				state_d = pmst_pkg::ST_IDLE;
			end
			pmst_pkg::ST_P_INIT: begin
				state_d = pmst_pkg::ST_U_RD;
			end
			pmst_pkg::ST_U_RD: begin
				t_addr  = u_q;
				state_d = pmst_pkg::ST_U_LAT;
			end
			pmst_pkg::ST_U_LAT: begin
				state_d = pmst_pkg::ST_SWEEP;
			end
			pmst_pkg::ST_SWEEP: begin
				if (i_last) begin
					state_d = pmst_pkg::ST_DRAIN;
				end
			end
			pmst_pkg::ST_DRAIN: begin
				state_d = pmst_pkg::ST_SEL;
			end
			pmst_pkg::ST_SEL: begin
				t_addr = minv_q;
				if (fnd_q) begin
					t_we    = !pass_q;
					state_d = pmst_pkg::ST_U_RD;
				end else if (!pass_q) begin
					state_d = pmst_pkg::ST_P_INIT;
				end else begin
					state_d = pmst_pkg::ST_OUT;
				end
			end
			pmst_pkg::ST_OUT: begin
				if (i_last) begin
					state_d = pmst_pkg::ST_OUT_DR;
				end
			end
			pmst_pkg::ST_OUT_DR: begin
				state_d = pmst_pkg::ST_IDLE;
			end
			default: state_d = pmst_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pmst_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q  <= pmst_pkg::CFG_BITS'(2);
			ca_q      <= '0;
			v_s1      <= 1'b0;
			res_valid <= 1'b0;
			in_tree_q <= '0;
			key_vld_q <= '0;
			tree_ok_q <= '0;
			pass_q    <= 1'b0;
			fnd_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				vcount_q <= cfg_wdata;
			end
			v_s1      <= (state_q == pmst_pkg::ST_SWEEP) || (state_q == pmst_pkg::ST_OUT);
			res_valid <= 1'b0;
			if (state_q == pmst_pkg::ST_CLEAR) begin
				ca_q <= ca_q + AW'(1);
			end
			unique case (state_q)
				pmst_pkg::ST_IDLE: begin
					ca_q   <= '0;
					pass_q <= 1'b0;
				end
				pmst_pkg::ST_P_INIT: begin
					in_tree_q <= MAX_VERTICES'(1);
					key_vld_q <= '0;
					if (!pass_q) begin
						tree_ok_q <= '0;
					end
				end
				pmst_pkg::ST_U_LAT: begin
					fnd_q <= 1'b0;
				end
				pmst_pkg::ST_SEL: begin
					if (fnd_q) begin
						in_tree_q[minv_q] <= 1'b1;
						if (!pass_q) begin
							tree_ok_q[minv_q] <= 1'b1;
						end
					end else begin
						pass_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
			// relax stage: track lowest key, lowest index on ties
			if (v_s1 && (state_q == pmst_pkg::ST_SWEEP || state_q == pmst_pkg::ST_DRAIN)) begin
				if (upd) begin
					key_vld_q[i_s1] <= 1'b1;
				end
				if (cand && (!fnd_q || (eff < min_q))) begin
					fnd_q <= 1'b1;
				end
			end
			if (v_s1 && (state_q == pmst_pkg::ST_OUT || state_q == pmst_pkg::ST_OUT_DR)) begin
				res_valid <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		i_s1 <= i_q;
		unique case (state_q)
			pmst_pkg::ST_IDLE: begin
				ab_q <= AW'(a_v) * AW'(MAX_VERTICES) + AW'(b_v);
				ba_q <= AW'(b_v) * AW'(MAX_VERTICES) + AW'(a_v);
				ew_q <= WB'(req.weight);
				if (start && (req.operation == pmst_pkg::OP_RUN)) begin
					nv_q <= nv_new;
				end
			end
			pmst_pkg::ST_E_CMP: begin
				if (w_rd_q[WB] || (ew_q < w_rd_q[WB-1:0])) begin
					nw_q   <= {1'b0, 1'b0, ew_q};
					doit_q <= 1'b1;
				end else if (ew_q == w_rd_q[WB-1:0]) begin
					nw_q   <= {1'b1, 1'b0, ew_q};
					doit_q <= 1'b1;
				end else begin
					nw_q   <= w_rd_q;
					doit_q <= 1'b0;
				end
			end
			pmst_pkg::ST_P_INIT: begin
				u_q     <= '0;
				row_q   <= '0;
				total_q <= '0;
				cnt_q   <= CW'(1);
			end
			pmst_pkg::ST_U_LAT: begin
				upar_q <= t_rd_q[VW+WB-1:WB];
				uok_q  <= tree_ok_q[u_q];
				i_q    <= '0;
			end
			pmst_pkg::ST_SWEEP: begin
				i_q <= i_q + VW'(1);
			end
			pmst_pkg::ST_SEL: begin
				if (fnd_q) begin
					u_q     <= minv_q;
					row_q   <= AW'(minv_q) * AW'(MAX_VERTICES);
					total_q <= total_q + TW'(min_q);
					cnt_q   <= cnt_q + CW'(1);
				end else if (!pass_q) begin
					tot1_q <= total_q;
					conn_q <= (cnt_q == nv_q);
				end else begin
					uniq_q <= (total_q == tot1_q + TW'(nv_q) - TW'(1));
					i_q    <= (nv_q == CW'(1)) ? VW'(0) : VW'(1);
				end
			end
			pmst_pkg::ST_OUT: begin
				i_q <= i_q + VW'(1);
			end
			default: begin
			end
		endcase
		if (v_s1 && (state_q == pmst_pkg::ST_SWEEP || state_q == pmst_pkg::ST_DRAIN)) begin
			if (cand && (!fnd_q || (eff < min_q))) begin
				min_q    <= eff;
				minv_q   <= i_s1;
				minpar_q <= upd ? u_q : k_rd_q[VW+WB:WB+1];
			end
		end
		if (v_s1 && (state_q == pmst_pkg::ST_OUT || state_q == pmst_pkg::ST_OUT_DR)) begin
			res.vertex        <= 6'(i_s1);
			res.parent_vertex <= tree_ok_q[i_s1] ? 6'(t_rd_q[VW+WB-1:WB]) : 6'd0;
			res.edge_weight   <= tree_ok_q[i_s1] ? 16'(t_rd_q[WB-1:0]) : 16'd0;
			res.total_weight  <= fin ? 22'(tot1_q) : 22'd0;
			res.unique_res    <= fin && uniq_q;
			res.connected     <= fin && conn_q;
			res.last          <= fin;
		end
	end

	assign fin = (CW'(i_s1) == (nv_q - CW'(1)));

endmodule

`default_nettype wire
